// ===== sv/csf_pkg.sv =====
// shared types, register codes and constants of the coupon spread filter
// depends on nothing; imported by every module of the block

package csf_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HASH_SEED    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUPON_LIMIT = 2'd1;

  // register reset values
  localparam logic [31:0] HASH_SEED_RST    = 32'd0;
  localparam logic [3:0]  COUPON_LIMIT_RST = 4'd9;

  // estimate saturation value
  localparam int unsigned EstW    = 7;
  localparam logic [EstW-1:0] EST_MAX = 7'd127;

  // murmur3 x86_32 constants
  localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2 = 32'h1b873593;
  localparam logic [31:0] MUR_C3 = 32'h85ebca6b;
  localparam logic [31:0] MUR_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MUR_N  = 32'he6546b64;
  localparam logic [31:0] MUR_LEN = 32'd4;

  // pipeline latencies of the hash and the constant modulo units
  localparam int unsigned HashLat = 6;
  localparam int unsigned ModLat  = 3;

  // control states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MODIFY
  } csf_state_e;

  // floor(b * (ln b - ln(b - c))), saturated; evaluated at elaboration only
  function automatic logic [EstW-1:0] est_entry(int b, int c);
    real v;
    if (c == 0) return '0;
    if (c >= b) return EST_MAX;
    v = real'(b) * ($ln(real'(b)) - $ln(real'(b - c)));
    if (v >= 127.0) return EST_MAX;
    return EstW'($rtoi(v));
  endfunction

endpackage

// ===== sv/csf_hash.sv =====
// six-stage pipelined murmur3 x86_32 hash of one 32-bit word
// depends on csf_pkg for the hash constants

module csf_hash import csf_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] word_i,
  input  logic [31:0] seed_i,
  output logic [31:0] hash_o
);

  logic [31:0] k1_q, k2_q, h1_q, h2_q, h3_q, hash_q;
  logic [31:0] k1_rot, h_mix, h_rot, h_add, h2_x;

  // body mixing of the single block
  assign k1_rot = {k1_q[16:0], k1_q[31:17]};
  assign h_mix  = seed_i ^ k2_q;
  assign h_rot  = {h_mix[18:0], h_mix[31:19]};
  assign h_add  = ((h_rot << 2) + h_rot + MUR_N) ^ MUR_LEN;
  assign h2_x   = h2_q ^ (h2_q >> 13);

  // at most one multiplier per stage
  always_ff @(posedge clk_i) begin
    k1_q   <= word_i * MUR_C1;
    k2_q   <= k1_rot * MUR_C2;
    h1_q   <= h_add ^ (h_add >> 16);
    h2_q   <= h1_q * MUR_C3;
    h3_q   <= h2_x * MUR_C4;
    hash_q <= h3_q ^ (h3_q >> 16);
  end

  assign hash_o = hash_q;

endmodule

// ===== sv/csf_mod.sv =====
// three-stage remainder of a 32-bit word by a build-time constant
// uses a reciprocal multiply with one correction step; depends on csf_pkg

module csf_mod import csf_pkg::*; #(
  parameter int unsigned DIVISOR = 12,
  parameter int unsigned OUT_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic             clk_i,
  input  logic [31:0]      value_i,
  output logic [OUT_W-1:0] rem_o
);

  localparam logic [32:0] Recip = 33'((64'd1 << 32) / DIVISOR);
  localparam logic [31:0] Div32 = 32'(DIVISOR);

  logic [64:0] quot_prod;
  logic [31:0] val1_q, quot_q, rem_q, out_q;

  // quotient estimate is exact or one short
  assign quot_prod = {33'd0, value_i} * {32'd0, Recip};

  always_ff @(posedge clk_i) begin
    val1_q <= value_i;
    quot_q <= quot_prod[63:32];
    rem_q  <= val1_q - 32'(quot_q * Div32);
    out_q  <= (rem_q >= Div32) ? (rem_q - Div32) : rem_q;
  end

  assign rem_o = out_q[OUT_W-1:0];

endmodule

// ===== sv/coupon_spread_filter.sv =====
// top level of the coupon spread filter: control, bitmap store, result register
// depends on csf_pkg, csf_hash and csf_mod

// Each beat on s_axis carries a flow key and an element (tdata) and an action
// (tuser: 0 update, 1 query). The key is hashed with murmur3 x86_32 under the
// hash seed register and selects one of NUM_BITMAPS bitmaps of BITMAP_WIDTH
// bits in a single-port synchronous store. An update below the coupon limit
// sets the bit picked by the element hash; otherwise it is flagged to_sketch.
// A query returns the coupon estimate and the to_sketch flag. Every input beat
// yields exactly one m_axis beat. One item is processed at a time: a beat passes
// nine stages of hash and modulo pipelines, one store read and one modify/write
// step, and the next beat is taken only after that step, which waits while the
// result register holds a beat that is not drained. After reset the store is
// cleared one entry per cycle over every entry; input beats wait during that
// pass while configuration writes are taken at any time.

module coupon_spread_filter import csf_pkg::*; #(
  parameter int unsigned NUM_BITMAPS  = 4096,
  parameter int unsigned BITMAP_WIDTH = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // flow_key[31:0], element_value[63:32]
  input  logic               s_axis_tuser,  // action[0]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [71:0]        m_axis_tdata,  // out_key[31:0], out_element[63:32],
                                            // estimate[70:64], zero[71]
  output logic [1:0]         m_axis_tuser   // was_query[0], to_sketch[1]
);

  localparam int unsigned IdxW  = (NUM_BITMAPS > 1) ? $clog2(NUM_BITMAPS) : 1;
  localparam int unsigned PosW  = $clog2(BITMAP_WIDTH);
  localparam int unsigned CntW  = $clog2(BITMAP_WIDTH + 1);
  localparam int unsigned CmpW  = (CntW > 4) ? CntW : 4;
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] ReadStep = StepW'(HashLat + ModLat);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(NUM_BITMAPS - 1);

  csf_state_e state_q, state_d;

  logic [31:0]      seed_q;
  logic [3:0]       limit_q;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0]  clr_idx_q;
  logic             action_q;
  logic [31:0]      key_q, elem_q;

  logic [31:0]      key_hash, elem_hash;
  logic [IdxW-1:0]  bm_idx;
  logic [PosW-1:0]  bit_pos;

  logic [BITMAP_WIDTH-1:0] bitmap_mem [NUM_BITMAPS];
  logic [BITMAP_WIDTH-1:0] rd_bits_q;
  logic [BITMAP_WIDTH-1:0] wr_bits;
  logic [IdxW-1:0]         wr_idx;
  logic                    wr_en;

  logic            in_ready, rd_en, modify_fire, clr_done;
  logic [CntW-1:0] bit_count;
  logic            full;
  logic [EstW-1:0] est_tab [BITMAP_WIDTH+1];

  logic        out_valid_q;
  logic [71:0] out_data_q;
  logic [1:0]  out_user_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= HASH_SEED_RST;
      limit_q <= COUPON_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HASH_SEED:    seed_q  <= cfg_data_i;
        CFG_COUPON_LIMIT: limit_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // input beat capture, held for the whole item
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      key_q    <= s_axis_tdata[31:0];
      elem_q   <= s_axis_tdata[63:32];
      action_q <= s_axis_tuser;
    end
  end

  // hash and modulo pipelines
  csf_hash u_key_hash (
    .clk_i  (clk_i),
    .word_i (key_q),
    .seed_i (seed_q),
    .hash_o (key_hash)
  );

  csf_hash u_elem_hash (
    .clk_i  (clk_i),
    .word_i (elem_q),
    .seed_i (seed_q),
    .hash_o (elem_hash)
  );

  csf_mod #(
    .DIVISOR (NUM_BITMAPS),
    .OUT_W   (IdxW)
  ) u_idx_mod (
    .clk_i   (clk_i),
    .value_i (key_hash),
    .rem_o   (bm_idx)
  );

  csf_mod #(
    .DIVISOR (BITMAP_WIDTH),
    .OUT_W   (PosW)
  ) u_pos_mod (
    .clk_i   (clk_i),
    .value_i (elem_hash),
    .rem_o   (bit_pos)
  );

  // state register, step counter and clearing pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      step_q    <= '0;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
      if (state_q == ST_HASH) step_q <= step_q + 1'b1;
      else                    step_q <= '0;
    end
  end

  assign clr_done = (clr_idx_q == LastIdx);

  // next state and control strobes
  always_comb begin
    state_d     = state_q;
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    modify_fire = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (s_axis_tvalid) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (step_q == ReadStep) begin
          rd_en   = 1'b1;
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (!out_valid_q || m_axis_tready) begin
          modify_fire = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign s_axis_tready = in_ready;

  // count of set bits in the fetched bitmap
  always_comb begin
    bit_count = '0;
    for (int i = 0; i < BITMAP_WIDTH; i++) begin
      bit_count = bit_count + CntW'(rd_bits_q[i]);
    end
  end

  assign full = (CmpW'(bit_count) >= CmpW'(limit_q));

  // estimate rom, one entry per possible count
  for (genvar c = 0; c <= BITMAP_WIDTH; c++) begin : g_est
    assign est_tab[c] = est_entry(BITMAP_WIDTH, c);
  end

  // store write: clearing pass or bit set of an update
  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_idx_q;
      wr_bits = '0;
    end else begin
      wr_en   = modify_fire && !action_q && !full;
      wr_idx  = bm_idx;
      wr_bits = rd_bits_q | (BITMAP_WIDTH'(1) << bit_pos);
    end
  end

  // bitmap store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) bitmap_mem[wr_idx] <= wr_bits;
    if (rd_en) rd_bits_q <= bitmap_mem[bm_idx];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (modify_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (modify_fire) begin
      out_data_q[31:0]  <= key_q;
      out_data_q[63:32] <= action_q ? 32'd0 : elem_q;
      out_data_q[70:64] <= action_q ? est_tab[bit_count] : '0;
      out_data_q[71]    <= 1'b0;
      out_user_q        <= {full, action_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
